### rtl/core/sco_pkg.sv
// ---------------------------------------------------------------------------
// sco_pkg: shared types and constants for the sphere/capsule overlap test
// Request and result structs, shape-pair modes and default widths.
// ---------------------------------------------------------------------------
package sco_pkg;

  localparam int PT_W     = 60;   // packed x,y,z point
  localparam int RADIUS_W = 16;   // unsigned Q8.8
  localparam int DIST_W   = 44;   // squared distance, saturated
  localparam int RADIUS_FRAC = 8;

  localparam int COORD_BITS_DEF     = 20;
  localparam int FRAC_BITS_DEF      = 8;
  localparam int RATE_FRAC_BITS_DEF = 16;

  // fixed stages around the divider in one projection unit
  localparam int PROJ_FIXED_STAGES = 6;

  typedef enum logic [1:0] {
    MODE_SS = 2'd0,   // sphere-sphere
    MODE_SC = 2'd1,   // sphere A, capsule B
    MODE_CC = 2'd2    // capsule-capsule
  } mode_t;

  typedef struct packed {
    logic [1:0]          mode;
    logic [PT_W-1:0]     a_start;
    logic [PT_W-1:0]     a_end;
    logic [RADIUS_W-1:0] a_radius;
    logic [PT_W-1:0]     b_start;
    logic [PT_W-1:0]     b_end;
    logic [RADIUS_W-1:0] b_radius;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] dist_sq;
    logic [PT_W-1:0]   near_a;
    logic [PT_W-1:0]   near_b;
  } res_t;

endpackage

### rtl/core/sco_proj.sv
// ---------------------------------------------------------------------------
// sco_proj: pipelined clamped projection of a point onto a segment
// Difference, products, sums, one divider stage per rate bit, scale, add.
// ---------------------------------------------------------------------------
module sco_proj #(
  parameter int C  = 20,
  parameter int R  = 16,
  parameter int TW = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [sco_pkg::PT_W-1:0] seg_s,
  input  logic [sco_pkg::PT_W-1:0] seg_e,
  input  logic [sco_pkg::PT_W-1:0] pt,
  input  logic [TW-1:0]          tag_in,
  output logic                   out_valid,
  output logic [sco_pkg::PT_W-1:0] near,
  output logic [TW-1:0]          tag_out
);
  import sco_pkg::*;

  localparam int VW = C + 1;
  localparam int PW = 2 * C + 2;
  localparam int SW = 2 * C + 4;
  localparam int RW = R + 1;
  localparam int MW = VW + RW + 1;

  // stage 1: vectors
  logic [63:0] sx, ex, px;
  logic signed [C-1:0]  s_c [3];
  logic signed [C-1:0]  e_c [3];
  logic signed [C-1:0]  p_c [3];
  logic signed [VW-1:0] vec1 [3];
  logic signed [VW-1:0] w1 [3];
  logic signed [C-1:0]  s1 [3];
  logic [TW-1:0]        tag1;
  logic                 v1;

  always_comb begin
    sx = 64'(seg_s);
    ex = 64'(seg_e);
    px = 64'(pt);
    for (int k = 0; k < 3; k++) begin
      s_c[k] = $signed(sx[k*C +: C]);
      e_c[k] = $signed(ex[k*C +: C]);
      p_c[k] = $signed(px[k*C +: C]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      vec1[k] <= VW'(e_c[k]) - VW'(s_c[k]);
      w1[k]   <= VW'(p_c[k]) - VW'(s_c[k]);
      s1[k]   <= s_c[k];
    end
    tag1 <= tag_in;
    if (rst) v1 <= 1'b0;
    else     v1 <= in_valid;
  end

  // stage 2: products
  logic signed [PW-1:0] pd2 [3];
  logic signed [PW-1:0] pl2 [3];
  logic signed [VW-1:0] vec2 [3];
  logic signed [C-1:0]  s2 [3];
  logic [TW-1:0]        tag2;
  logic                 v2;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      pd2[k]  <= PW'(vec1[k]) * PW'(w1[k]);
      pl2[k]  <= PW'(vec1[k]) * PW'(vec1[k]);
      vec2[k] <= vec1[k];
      s2[k]   <= s1[k];
    end
    tag2 <= tag1;
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
  end

  // stage 3: dot and squared length
  logic signed [SW-1:0] dot3, len3;
  logic signed [VW-1:0] vec3 [3];
  logic signed [C-1:0]  s3 [3];
  logic [TW-1:0]        tag3;
  logic                 v3;

  always_ff @(posedge clk) begin
    dot3 <= SW'(pd2[0]) + SW'(pd2[1]) + SW'(pd2[2]);
    len3 <= SW'(pl2[0]) + SW'(pl2[1]) + SW'(pl2[2]);
    vec3 <= vec2;
    s3   <= s2;
    tag3 <= tag2;
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
  end

  // stage 4 and divider: index 0 is the set-up register, one bit per stage
  logic [SW-1:0]        drem [R+1];
  logic [SW-1:0]        dd   [R+1];
  logic [R-1:0]         dq   [R+1];
  logic                 dz   [R+1];
  logic                 d1   [R+1];
  logic signed [VW-1:0] dvec [R+1][3];
  logic signed [C-1:0]  ds   [R+1][3];
  logic [TW-1:0]        dtag [R+1];
  logic                 dv   [R+1];

  always_ff @(posedge clk) begin
    drem[0] <= dot3;
    dd[0]   <= len3;
    dq[0]   <= '0;
    dz[0]   <= (len3 == '0) || (dot3 <= 0);
    d1[0]   <= (dot3 >= len3);
    dvec[0] <= vec3;
    ds[0]   <= s3;
    dtag[0] <= tag3;
    if (rst) dv[0] <= 1'b0;
    else     dv[0] <= v3;
  end

  for (genvar i = 0; i < R; i++) begin : g_div
    logic [SW:0] trial;
    logic [SW:0] diff;
    assign trial = {drem[i], 1'b0};
    assign diff  = trial - {1'b0, dd[i]};
    always_ff @(posedge clk) begin
      if (!diff[SW]) begin
        drem[i+1] <= diff[SW-1:0];
        dq[i+1]   <= {dq[i][R-2:0], 1'b1};
      end else begin
        drem[i+1] <= trial[SW-1:0];
        dq[i+1]   <= {dq[i][R-2:0], 1'b0};
      end
      dd[i+1]   <= dd[i];
      dz[i+1]   <= dz[i];
      d1[i+1]   <= d1[i];
      dvec[i+1] <= dvec[i];
      ds[i+1]   <= ds[i];
      dtag[i+1] <= dtag[i];
      if (rst) dv[i+1] <= 1'b0;
      else     dv[i+1] <= dv[i];
    end
  end

  // stage 5: scale the vector by the clamped rate
  logic [RW-1:0]        rate;
  logic signed [MW-1:0] prod5 [3];
  logic signed [C-1:0]  s5 [3];
  logic [TW-1:0]        tag5;
  logic                 v5;

  always_comb begin
    if (dz[R])      rate = '0;
    else if (d1[R]) rate = RW'(1) << R;
    else            rate = {1'b0, dq[R]};
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      prod5[k] <= MW'(dvec[R][k]) * MW'($signed({1'b0, rate}));
      s5[k]    <= ds[R][k];
    end
    tag5 <= dtag[R];
    if (rst) v5 <= 1'b0;
    else     v5 <= dv[R];
  end

  // stage 6: round half up, add to start, pack
  logic signed [MW-1:0] rnd [3];
  logic signed [MW-1:0] stepv [3];
  logic [63:0]          packed_pt;

  always_comb begin
    packed_pt = '0;
    for (int k = 0; k < 3; k++) begin
      rnd[k]   = prod5[k] + (MW'(1) <<< (R - 1));
      stepv[k] = rnd[k] >>> R;
      packed_pt[k*C +: C] = C'(s5[k] + stepv[k][C-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    near    <= packed_pt[PT_W-1:0];
    tag_out <= tag5;
    if (rst) out_valid <= 1'b0;
    else     out_valid <= v5;
  end

endmodule

### rtl/core/sphere_capsule_overlap_test_top.sv
// ---------------------------------------------------------------------------
// sphere_capsule_overlap_test_top: streaming sphere/capsule pair test
// Two chained projection pipelines, then distance and radius compare.
// ---------------------------------------------------------------------------
// A pair request is taken on every cycle that start is high; busy is always
// low, as the pipeline never holds off. Each result appears on res for one
// cycle with done high, in request order, after passing through the two
// projection units in series, each with one restoring divider stage per
// rate bit, then the distance stages and the result register. Results
// cannot be back-pressured: the receiver must take every done cycle.
module sphere_capsule_overlap_test_top #(
  parameter int COORD_BITS     = sco_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS      = sco_pkg::FRAC_BITS_DEF,
  parameter int RATE_FRAC_BITS = sco_pkg::RATE_FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  sco_pkg::req_t req,
  output logic          done,
  output sco_pkg::res_t res
);
  import sco_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int VW  = C + 1;
  localparam int PW  = 2 * C + 2;
  localparam int SW  = 2 * C + 4;
  localparam int RSW = RADIUS_W + 1;
  localparam int RQW = 2 * RSW;
  localparam int LSH = (2 * FRAC_BITS >= 2 * RADIUS_FRAC) ? 0 : 2 * RADIUS_FRAC - 2 * FRAC_BITS;
  localparam int RSH = (2 * FRAC_BITS >= 2 * RADIUS_FRAC) ? 2 * FRAC_BITS - 2 * RADIUS_FRAC : 0;
  localparam int LAT = 2 * (RATE_FRAC_BITS + PROJ_FIXED_STAGES) + 3;
  localparam int T1W = 2 + 3 * PT_W + RSW;
  localparam int T2W = PT_W + RSW;

  localparam logic [63:0] MASK64 = (64'd1 << (3 * C)) - 64'd1;
  localparam logic [PT_W-1:0] PT_MASK = MASK64[PT_W-1:0];

  assign busy = 1'b0;

  // ---- first projection: b_start onto segment A ----
  logic [RSW-1:0] rsum_in;
  logic [T1W-1:0] tag1_in, tag1_out;
  logic           p1_valid;
  logic [PT_W-1:0] near1;

  assign rsum_in = RSW'(req.a_radius) + RSW'(req.b_radius);
  assign tag1_in = {req.mode, req.a_start, req.b_start, req.b_end, rsum_in};

  sco_proj #(.C(C), .R(RATE_FRAC_BITS), .TW(T1W)) u_proj_a (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start),
    .seg_s    (req.a_start),
    .seg_e    (req.a_end),
    .pt       (req.b_start),
    .tag_in   (tag1_in),
    .out_valid(p1_valid),
    .near     (near1),
    .tag_out  (tag1_out)
  );

  // ---- pick near_a and segment B end by mode ----
  logic [1:0]      m1;
  logic [PT_W-1:0] as1, bs1, be1, na1, seg_b_end;
  logic [RSW-1:0]  rsum1;

  assign {m1, as1, bs1, be1, rsum1} = tag1_out;

  always_comb begin
    unique case (m1)
      MODE_SS: begin
        // degenerate segment: projection lands on b_start
        na1       = as1 & PT_MASK;
        seg_b_end = bs1;
      end
      MODE_SC: begin
        na1       = as1 & PT_MASK;
        seg_b_end = be1;
      end
      default: begin
        na1       = near1;
        seg_b_end = be1;
      end
    endcase
  end

  // ---- second projection: near_a onto segment B ----
  logic [T2W-1:0]  tag2_out;
  logic            p2_valid;
  logic [PT_W-1:0] near2, na2;
  logic [RSW-1:0]  rsum2;

  sco_proj #(.C(C), .R(RATE_FRAC_BITS), .TW(T2W)) u_proj_b (
    .clk      (clk),
    .rst      (rst),
    .in_valid (p1_valid),
    .seg_s    (bs1),
    .seg_e    (seg_b_end),
    .pt       (na1),
    .tag_in   ({na1, rsum1}),
    .out_valid(p2_valid),
    .near     (near2),
    .tag_out  (tag2_out)
  );

  assign {na2, rsum2} = tag2_out;

  // ---- distance stage 1: coordinate differences, radius sum squared ----
  logic [63:0]          na64, nb64;
  logic signed [VW-1:0] dif1 [3];
  logic [RQW-1:0]       rsq1;
  logic [PT_W-1:0]      na_d1, nb_d1;
  logic                 v_d1;

  assign na64 = 64'(na2);
  assign nb64 = 64'(near2);

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      dif1[k] <= VW'($signed(na64[k*C +: C])) - VW'($signed(nb64[k*C +: C]));
    end
    rsq1  <= RQW'(rsum2) * RQW'(rsum2);
    na_d1 <= na2;
    nb_d1 <= near2;
    if (rst) v_d1 <= 1'b0;
    else     v_d1 <= p2_valid;
  end

  // ---- distance stage 2: squares ----
  logic signed [PW-1:0] sq2 [3];
  logic [RQW-1:0]       rsq2;
  logic [PT_W-1:0]      na_d2, nb_d2;
  logic                 v_d2;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      sq2[k] <= PW'(dif1[k]) * PW'(dif1[k]);
    end
    rsq2  <= rsq1;
    na_d2 <= na_d1;
    nb_d2 <= nb_d1;
    if (rst) v_d2 <= 1'b0;
    else     v_d2 <= v_d1;
  end

  // ---- distance stage 3: sum, compare at equal scale, saturate ----
  logic [SW-1:0] dist_sum;
  logic [63:0]   lhs, rhs;
  logic [DIST_W-1:0] dist_sat;

  always_comb begin
    dist_sum = SW'(sq2[0]) + SW'(sq2[1]) + SW'(sq2[2]);
    lhs      = 64'(dist_sum) << LSH;
    rhs      = 64'(rsq2) << RSH;
    if (64'(dist_sum) > 64'({DIST_W{1'b1}})) dist_sat = '1;
    else                                     dist_sat = DIST_W'(dist_sum);
  end

  always_ff @(posedge clk) begin
    res.hit     <= (lhs <= rhs);
    res.dist_sq <= dist_sat;
    res.near_a  <= na_d2;
    res.near_b  <= nb_d2;
    if (rst) done <= 1'b0;
    else     done <= v_d2;
  end

  // ---- checks ----
  a_lat_fwd: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LAT done)
    else $error("request did not produce a result at the fixed latency");

  a_lat_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !rst, LAT))
    else $error("result strobe without a matching request");

  a_hit_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (res.dist_sq == '0)) |-> res.hit)
    else $error("zero distance reported as a miss");

endmodule
